// ===== sv/prqs_pkg.sv =====
// ----------------------------------------------------------------------------
// prqs_pkg: shared definitions of the priority ready queue scheduler
// Sizes of the thread and level tables, command and status codes.
// ----------------------------------------------------------------------------
package prqs_pkg;

	// Table sizes. A null link is the value THREADS.
	localparam int THREADS = 8;
	localparam int LEVELS  = 16;
	localparam int TID_W   = $clog2(THREADS);
	localparam int PTR_W   = $clog2(THREADS + 1);
	localparam int LVL_W   = $clog2(LEVELS);
	localparam logic [PTR_W-1:0] NIL = PTR_W'(THREADS);

	// Widths of the stream words.
	localparam int IN_W  = 16;
	localparam int OUT_W = 16;

	typedef enum logic [2:0] {
		OP_CREATE   = 3'd0,
		OP_EXIT     = 3'd1,
		OP_READY    = 3'd2,
		OP_RUN      = 3'd3,
		OP_PRIORITY = 3'd4,
		OP_SCHEDULE = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ALREADY   = 3'd1,
		ST_UNUSED    = 3'd2,
		ST_NO_SLOT   = 3'd3,
		ST_NOTHING   = 3'd4,
		ST_NOT_HEAD  = 3'd5
	} status_t;

endpackage

// ===== sv/priority_ready_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler: multilevel FIFO ready queue
// Keeps one linked FIFO of ready threads per priority level and executes
// one scheduler command per input word, returning one status word.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the s_ stream; each accepted word carries an opcode, a
// thread slot and a requested level. Every command produces exactly one
// result word on the m_ stream with a status, a thread slot and a level.
// A small sequencer works each command through the shared tables in steps:
// fetch the slot entry and the head of its level and decide, then update
// the links, head and tail, then load the output register. A new word is
// taken only once the sequencer is back in idle, after the result of the
// last one has been loaded into the output register. Schedule instead
// walks the level heads one per cycle through a single compare, from the
// most urgent level down, and goes from the walk straight to the output
// register. s_tready is high only while the sequencer is idle.
// The result register decouples the two sides: a new command is accepted
// while a finished result still waits, but a second result is held back
// until m_tready takes the first. After reset all slots are free, nothing
// is ready, every head, tail and link is null, and no result is pending.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// s_tdata, from bit 0 up: opcode[2:0], thread_id[5:3], priority_req[10:6]
	input  logic [prqs_pkg::IN_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// m_tdata, from bit 0 up: status[2:0], result_thread[5:3], old_priority[9:6]
	output logic [prqs_pkg::OUT_W-1:0] m_tdata
);
	import prqs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_EXEC,
		S_SCAN,
		S_DONE
	} state_t;

	// Table update chosen in the fetch step.
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ENQ,
		ACT_DEQ,
		ACT_FREE,
		ACT_DEQ_FREE
	} action_t;

	state_t               state_q;
	action_t              act_q;

	// Thread and level tables.
	logic [THREADS-1:0]   used_q;
	logic [THREADS-1:0]   ready_q;
	logic [LVL_W-1:0]     level_q [THREADS];
	logic [PTR_W-1:0]     next_q  [THREADS];
	logic [PTR_W-1:0]     head_q  [LEVELS];
	logic [PTR_W-1:0]     tail_q  [LEVELS];

	// Latched command and working registers.
	opcode_t              op_q;
	logic [TID_W-1:0]     tgt_q;
	logic                 no_slot_q;
	logic signed [4:0]    preq_q;
	logic [LVL_W-1:0]     lvl_q;
	logic [LVL_W-1:0]     scan_q;
	status_t              status_q;
	logic [TID_W-1:0]     res_q;
	logic [LVL_W-1:0]     oldp_q;

	// Result register.
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [TID_W-1:0]     out_thread_q;
	logic [LVL_W-1:0]     out_level_q;

	// Fields of the incoming word.
	logic [2:0]           in_opcode;
	logic [TID_W-1:0]     in_thread;
	logic signed [4:0]    in_preq;

	assign in_opcode = s_tdata[2:0];
	assign in_thread = s_tdata[5:3];
	assign in_preq   = s_tdata[10:6];

	// Lowest free slot, found from the used bits.
	logic [TID_W-1:0]     free_idx;
	logic                 free_any;

	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = THREADS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = TID_W'(i);
				free_any = 1'b1;
			end
		end
	end

	// Slot entry of the target and the head of its level.
	logic                 cur_used;
	logic                 cur_ready;
	logic [LVL_W-1:0]     cur_lvl;
	logic                 cur_is_head;
	logic                 keep_lvl;
	logic [4:0]           preq_u;
	logic [LVL_W-1:0]     req_lvl;
	logic [LVL_W-1:0]     new_lvl;

	always_comb begin
		cur_used    = used_q[tgt_q];
		cur_ready   = ready_q[tgt_q];
		cur_lvl     = level_q[tgt_q];
		cur_is_head = (head_q[cur_lvl] == PTR_W'(tgt_q));
		keep_lvl    = preq_q[4];
		preq_u      = $unsigned(preq_q);
		// A level beyond the table saturates to the least urgent one.
		req_lvl     = (int'(preq_u) < LEVELS) ? LVL_W'(preq_u) : LVL_W'(LEVELS - 1);
		new_lvl     = keep_lvl ? cur_lvl : req_lvl;
	end

	// Scan compare: does the level under the scan pointer hold a thread?
	logic [PTR_W-1:0]     scan_head;
	logic                 scan_hit;

	assign scan_head = head_q[scan_q];
	assign scan_hit  = (scan_head < NIL);

	// Tail of the working level and link of the target for the update step.
	logic [PTR_W-1:0]     work_tail;
	logic [PTR_W-1:0]     work_next;

	assign work_tail = tail_q[lvl_q];
	assign work_next = next_q[tgt_q];

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		m_tdata      = '0;
		m_tdata[2:0] = out_status_q;
		m_tdata[5:3] = out_thread_q;
		m_tdata[9:6] = out_level_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			act_q        <= ACT_NONE;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_thread_q <= '0;
			out_level_q  <= '0;
			op_q         <= OP_CREATE;
			tgt_q        <= '0;
			no_slot_q    <= 1'b0;
			preq_q       <= '0;
			lvl_q        <= '0;
			scan_q       <= '0;
			status_q     <= ST_OK;
			res_q        <= '0;
			oldp_q       <= '0;
			used_q       <= '0;
			ready_q      <= '0;
			for (int i = 0; i < THREADS; i++) begin
				level_q[i] <= '0;
				next_q[i]  <= NIL;
			end
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
		end else begin
			// A result taken while the next one is loaded stays valid below.
			if (out_valid_q && m_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q      <= opcode_t'(in_opcode);
						preq_q    <= in_preq;
						tgt_q     <= (in_opcode == OP_CREATE) ? free_idx : in_thread;
						no_slot_q <= !free_any;
						scan_q    <= '0;
						state_q   <= S_FETCH;
					end
				end

				S_FETCH: begin
					// Decide the outcome from the slot entry; tables stay untouched.
					act_q    <= ACT_NONE;
					status_q <= ST_OK;
					res_q    <= '0;
					oldp_q   <= '0;
					lvl_q    <= cur_lvl;
					state_q  <= S_EXEC;
					priority case (1'b1)
						(op_q == OP_CREATE): begin
							if (no_slot_q) begin
								status_q <= ST_NO_SLOT;
							end else begin
								act_q  <= ACT_ENQ;
								lvl_q  <= new_lvl;
								res_q  <= tgt_q;
								oldp_q <= new_lvl;
							end
						end
						(op_q == OP_SCHEDULE): begin
							state_q <= S_SCAN;
						end
						(op_q != OP_EXIT && op_q != OP_READY && op_q != OP_RUN &&
						 op_q != OP_PRIORITY): begin
							// Unknown opcode: plain ok, nothing changes.
						end
						(!cur_used): begin
							status_q <= ST_UNUSED;
							oldp_q   <= cur_lvl;
						end
						default: begin
							oldp_q <= cur_lvl;
							unique case (op_q)
								OP_EXIT: begin
									if (cur_ready && !cur_is_head) begin
										status_q <= ST_NOT_HEAD;
									end else begin
										act_q <= cur_ready ? ACT_DEQ_FREE : ACT_FREE;
									end
								end
								OP_READY: begin
									if (cur_ready) begin
										status_q <= ST_ALREADY;
									end else begin
										act_q <= ACT_ENQ;
									end
								end
								OP_RUN: begin
									if (!cur_ready) begin
										status_q <= ST_ALREADY;
									end else if (!cur_is_head) begin
										status_q <= ST_NOT_HEAD;
									end else begin
										act_q <= ACT_DEQ;
									end
								end
								default: begin
									// Change of priority.
									if (cur_ready) begin
										status_q <= ST_ALREADY;
									end else begin
										act_q <= ACT_ENQ;
										lvl_q <= new_lvl;
									end
								end
							endcase
						end
					endcase
				end

				S_SCAN: begin
					// One level head checked per cycle, most urgent first.
					if (scan_hit) begin
						res_q    <= scan_head[TID_W-1:0];
						oldp_q   <= scan_q;
						state_q  <= S_DONE;
					end else if (scan_q == LVL_W'(LEVELS - 1)) begin
						status_q <= ST_NOTHING;
						state_q  <= S_DONE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end

				S_EXEC: begin
					unique case (act_q)
						ACT_ENQ: begin
							// Append at the tail of the working level.
							if (work_tail < NIL) begin
								next_q[work_tail[TID_W-1:0]] <= PTR_W'(tgt_q);
							end else begin
								head_q[lvl_q] <= PTR_W'(tgt_q);
							end
							tail_q[lvl_q]  <= PTR_W'(tgt_q);
							next_q[tgt_q]  <= NIL;
							level_q[tgt_q] <= lvl_q;
							used_q[tgt_q]  <= 1'b1;
							ready_q[tgt_q] <= 1'b1;
						end
						ACT_DEQ, ACT_DEQ_FREE: begin
							// The target heads its level: its successor becomes head.
							head_q[lvl_q] <= work_next;
							if (!(work_next < NIL)) begin
								tail_q[lvl_q] <= NIL;
							end
							ready_q[tgt_q] <= 1'b0;
							next_q[tgt_q]  <= NIL;
							if (act_q == ACT_DEQ_FREE) begin
								used_q[tgt_q]  <= 1'b0;
								level_q[tgt_q] <= '0;
							end
						end
						ACT_FREE: begin
							used_q[tgt_q]  <= 1'b0;
							ready_q[tgt_q] <= 1'b0;
							level_q[tgt_q] <= '0;
							next_q[tgt_q]  <= NIL;
						end
						default: begin
						end
					endcase
					state_q <= S_DONE;
				end

				S_DONE: begin
					// Load the result once the previous one has left.
					if (!out_valid_q || m_tready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_thread_q <= res_q;
						out_level_q  <= oldp_q;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the priority ready queue scheduler
// Commands are streamed into the block with random gaps, and each status
// word is checked against a software copy of the thread and queue tables.
// ----------------------------------------------------------------------------
module tb_top;
	import prqs_pkg::*;

	// Opcodes the block does not define. They must leave the tables alone.
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	// Requested levels with the sign bit set keep the slot's present level.
	localparam logic [4:0] PRIO_KEEP     = 5'b11111;
	localparam logic [4:0] PRIO_KEEP_MIN = 5'b10000;

	localparam int RANDOM_CMDS = 700;
	localparam int IDLE_PCT    = 19;

	// One command word; the last field sits in the lowest bits.
	typedef struct packed {
		logic [4:0]       prio;
		logic [TID_W-1:0] tid;
		logic [2:0]       op;
	} sched_cmd_t;

	// One status word; the last field sits in the lowest bits.
	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [TID_W-1:0] thread;
		logic [2:0]       status;
	} sched_result_t;

	// Full copy of the scheduler tables.
	typedef struct packed {
		logic [THREADS-1:0]            used;
		logic [THREADS-1:0]            ready;
		logic [THREADS-1:0][LVL_W-1:0] level;
		logic [THREADS-1:0][PTR_W-1:0] link;
		logic [LEVELS-1:0][PTR_W-1:0]  head;
		logic [LEVELS-1:0][PTR_W-1:0]  tail;
	} sched_state_t;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;

	sched_cmd_t          pending_cmds[$];     // commands not yet offered
	sched_result_t       expected_status[$];  // status words still owed
	sched_state_t        tables;              // tables as seen by accepted words
	sched_state_t        plan;                // tables as the generator sees them
	sched_cmd_t          word_cmd;            // command currently on s_tdata
	int                  total_cmds  = 0;
	int                  words_in    = 0;
	int                  words_out   = 0;
	int                  errors      = 0;
	int                  status_seen[6];

	priority_ready_queue_scheduler u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous ceiling: even the slowest legal run needs well under a
	// tenth of this.
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// --------------------------------------------------------------------
	// Table model
	// --------------------------------------------------------------------

	// Appends slot t at the tail of its level's FIFO and marks it ready.
	function automatic void queue_append(inout sched_state_t s, input int t);
		int l;
		l = s.level[t];
		if (s.tail[l] != NIL)
			s.link[s.tail[l]] = PTR_W'(t);
		else
			s.head[l] = PTR_W'(t);
		s.tail[l] = PTR_W'(t);
		s.link[t] = NIL;
		s.ready[t] = 1'b1;
	endfunction

	// Removes slot t, which must head its level, from the FIFO.
	function automatic void queue_pop(inout sched_state_t s, input int t);
		int l;
		l = s.level[t];
		s.head[l] = s.link[t];
		if (s.head[l] == NIL)
			s.tail[l] = NIL;
		s.ready[t] = 1'b0;
		s.link[t] = NIL;
	endfunction

	// Executes one command on the tables and returns the status word that
	// the block must produce for it.
	function automatic sched_result_t run_command(inout sched_state_t s,
		input sched_cmd_t c);
		sched_result_t    r;
		int               t;
		int               i;
		bit               keep;
		bit               known;
		bit               is_head;
		logic [LVL_W-1:0] want;
		r = '0;
		t = c.tid;
		keep = c.prio[4];
		// A non-negative request always fits the level range, so the
		// saturation to the last level never comes into play here.
		want = c.prio[3:0];
		known = s.used[t];
		is_head = s.head[s.level[t]] == PTR_W'(t);
		case (c.op)
			OP_CREATE: begin
				for (i = 0; i < THREADS; i++)
					if (!s.used[i])
						break;
				if (i == THREADS) begin
					r.status = ST_NO_SLOT;
				end else begin
					s.used[i] = 1'b1;
					s.ready[i] = 1'b0;
					s.link[i] = NIL;
					if (!keep)
						s.level[i] = want;
					queue_append(s, i);
					r.thread = TID_W'(i);
					r.level = s.level[i];
				end
			end
			OP_EXIT: begin
				r.level = s.level[t];
				if (!known) begin
					r.status = ST_UNUSED;
				end else if (s.ready[t] && !is_head) begin
					r.status = ST_NOT_HEAD;
				end else begin
					if (s.ready[t])
						queue_pop(s, t);
					s.used[t] = 1'b0;
					s.ready[t] = 1'b0;
					s.level[t] = '0;
					s.link[t] = NIL;
				end
			end
			OP_READY: begin
				r.level = s.level[t];
				if (!known)
					r.status = ST_UNUSED;
				else if (s.ready[t])
					r.status = ST_ALREADY;
				else
					queue_append(s, t);
			end
			OP_RUN: begin
				r.level = s.level[t];
				if (!known)
					r.status = ST_UNUSED;
				else if (!s.ready[t])
					r.status = ST_ALREADY;
				else if (!is_head)
					r.status = ST_NOT_HEAD;
				else
					queue_pop(s, t);
			end
			OP_PRIORITY: begin
				r.level = s.level[t];
				if (!known) begin
					r.status = ST_UNUSED;
				end else if (s.ready[t]) begin
					r.status = ST_ALREADY;
				end else begin
					if (!keep)
						s.level[t] = want;
					queue_append(s, t);
				end
			end
			OP_SCHEDULE: begin
				for (i = 0; i < LEVELS; i++)
					if (s.head[i] != NIL)
						break;
				if (i == LEVELS) begin
					r.status = ST_NOTHING;
				end else begin
					r.thread = s.head[i][TID_W-1:0];
					r.level = LVL_W'(i);
				end
			end
			default: begin
				// Spare opcodes answer with an all-zero word.
			end
		endcase
		return r;
	endfunction

	function automatic sched_state_t empty_tables();
		sched_state_t s;
		int           i;
		s = '0;
		for (i = 0; i < THREADS; i++)
			s.link[i] = NIL;
		for (i = 0; i < LEVELS; i++) begin
			s.head[i] = NIL;
			s.tail[i] = NIL;
		end
		return s;
	endfunction

	// Queues one command and advances the generator's view of the tables,
	// so that later commands can be aimed at threads in a useful state.
	task automatic plan_cmd(input logic [2:0] op, input int tid, input logic [4:0] prio);
		sched_cmd_t c;
		c.op = op;
		c.tid = TID_W'(tid);
		c.prio = prio;
		pending_cmds.push_back(c);
		void'(run_command(plan, c));
		total_cmds++;
	endtask

	// --------------------------------------------------------------------
	// Idling. Both sides stall about one cycle in five, except during a
	// stretch of the run where words are offered and taken back to back.
	// --------------------------------------------------------------------
	function automatic bit take_gap();
		if (words_in >= 320 && words_in < 440)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	// Command driver. A word is predicted at the edge that accepts it; the
	// next word, if any, goes on the bus at that same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_status.push_back(run_command(tables, word_cmd));
				words_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0 && !take_gap()) begin
					word_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= IN_W'(word_cmd);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Status monitor. Every accepted word is compared field by field with
	// the oldest outstanding prediction.
	always @(posedge clk or negedge arst_n) begin
		sched_result_t got;
		sched_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(sched_result_t)-1:0];
				words_out++;
				if (expected_status.size() == 0) begin
					$display("%0t: unexpected status word %h", $time, m_tdata);
					errors++;
				end else begin
					want = expected_status.pop_front();
					if (want.status < 6)
						status_seen[want.status]++;
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
						errors++;
					end
					if (got.thread !== want.thread) begin
						$display("%0t: result_thread expected %0d actual %0d",
							$time, want.thread, got.thread);
						errors++;
					end
					if (got.level !== want.level) begin
						$display("%0t: old_priority expected %0d actual %0d",
							$time, want.level, got.level);
						errors++;
					end
				end
			end
			m_tready <= !take_gap();
		end
	end

	// --------------------------------------------------------------------
	// Stimulus and end of run
	// --------------------------------------------------------------------
	initial begin
		int         n;
		int         t;
		int         roll;
		logic [2:0] op;
		logic [4:0] prio;
		int         tid;
		int         heads[$];
		int         idlers[$];

		tables = empty_tables();
		plan = empty_tables();
		for (n = 0; n < 6; n++)
			status_seen[n] = 0;

		// Directed part. With empty tables: schedule finds nothing, and
		// every per-thread command hits an unused slot.
		plan_cmd(OP_SCHEDULE, 0, 5'd0);
		plan_cmd(OP_EXIT, 3, 5'd0);
		plan_cmd(OP_READY, 0, 5'd0);
		plan_cmd(OP_RUN, 0, 5'd0);
		plan_cmd(OP_PRIORITY, 7, 5'd9);
		// Slots 0, 1 and 2 at the most urgent level, the last level, and
		// a kept level (zero after reset). Level 0 then holds 0 then 2.
		plan_cmd(OP_CREATE, 5, 5'd0);
		plan_cmd(OP_CREATE, 0, 5'd15);
		plan_cmd(OP_CREATE, 7, PRIO_KEEP);
		plan_cmd(OP_READY, 0, 5'd0);       // already ready
		plan_cmd(OP_RUN, 2, 5'd0);         // ready but behind slot 0
		plan_cmd(OP_EXIT, 2, 5'd0);        // same, exit refused
		plan_cmd(OP_SCHEDULE, 0, 5'd0);
		plan_cmd(OP_RUN, 0, 5'd0);
		plan_cmd(OP_RUN, 0, 5'd0);         // no longer ready
		plan_cmd(OP_PRIORITY, 0, 5'd7);
		plan_cmd(OP_PRIORITY, 0, 5'd3);    // ready, level stays 7
		plan_cmd(OP_EXIT, 2, 5'd0);        // now heads level 0
		// The freed slot comes back with its level cleared to zero.
		plan_cmd(OP_CREATE, 0, PRIO_KEEP_MIN);
		plan_cmd(OP_RUN, 1, 5'd0);
		plan_cmd(OP_EXIT, 1, 5'd0);        // exit of a thread not ready
		for (n = 0; n < 6; n++)
			plan_cmd(OP_CREATE, 0, (n % 2) ? 5'd15 : 5'(n));
		plan_cmd(OP_CREATE, 0, 5'd4);      // table full
		plan_cmd(OP_SPARE6, 5, 5'b10101);
		plan_cmd(OP_SPARE7, 2, 5'b01010);

		// Random part. Most commands are aimed at a thread for which the
		// command does real work; the rest are arbitrary words.
		for (n = 0; n < RANDOM_CMDS; n++) begin
			heads.delete();
			idlers.delete();
			for (t = 0; t < THREADS; t++) begin
				if (plan.ready[t] && plan.head[plan.level[t]] == PTR_W'(t))
					heads.push_back(t);
				if (plan.used[t] && !plan.ready[t])
					idlers.push_back(t);
			end
			tid = $urandom_range(THREADS - 1);
			prio = 5'($urandom);
			if ($urandom_range(99) < 85) begin
				roll = $urandom_range(99);
				if (roll < 18)
					op = OP_CREATE;
				else if (roll < 30)
					op = OP_EXIT;
				else if (roll < 45)
					op = OP_READY;
				else if (roll < 63)
					op = OP_RUN;
				else if (roll < 78)
					op = OP_PRIORITY;
				else
					op = OP_SCHEDULE;

				roll = $urandom_range(99);
				if (roll < 15)
					prio = 5'($urandom_range(16, 31));
				else if (roll < 25)
					prio = $urandom_range(1) ? 5'd15 : 5'd0;
				else
					prio = 5'($urandom_range(0, 15));

				if ((op == OP_RUN || op == OP_EXIT) && heads.size() != 0 &&
					$urandom_range(99) < 75)
					tid = heads[$urandom_range(heads.size() - 1)];
				else if (op == OP_EXIT && idlers.size() != 0 &&
					$urandom_range(99) < 60)
					tid = idlers[$urandom_range(idlers.size() - 1)];
				else if ((op == OP_READY || op == OP_PRIORITY) &&
					idlers.size() != 0 && $urandom_range(99) < 80)
					tid = idlers[$urandom_range(idlers.size() - 1)];
			end else begin
				op = 3'($urandom_range(7));
			end
			plan_cmd(op, tid, prio);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// A short drain after the last status word catches any strays.
		while (!(words_in == total_cmds && expected_status.size() == 0))
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d commands and checked %0d status words.", total_cmds, words_out);
		$display("Statuses: ok %0d, already %0d, unused %0d, no slot %0d, nothing %0d, not head %0d",
			status_seen[ST_OK], status_seen[ST_ALREADY], status_seen[ST_UNUSED],
			status_seen[ST_NO_SLOT], status_seen[ST_NOTHING], status_seen[ST_NOT_HEAD]);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/prqs_pkg.sv
sv/priority_ready_queue_scheduler.sv
tb/tb_top.sv
